### design/qslerp_pkg.sv
`default_nettype none

package qslerp_pkg;

    typedef struct packed {
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] first_z;
        logic signed [15:0] first_w;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic signed [15:0] second_z;
        logic signed [15:0] second_w;
        logic [14:0]        blend;
    } req_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic signed [15:0] out_w;
    } rsp_t;

    typedef struct packed {
        req_t        item;
        logic        flip;
        logic        linear;
    } tag_t;

    typedef struct packed {
        tag_t        tag;
        logic [28:0] mag;
    } job_t;

    localparam int ATAN_ENTRIES = 24;
    localparam int SQRT_STEPS   = 29;
    localparam int DIV_STEPS    = 16;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = 2;

    localparam logic [14:0]        ONE_Q14      = 15'd16384;
    localparam logic [28:0]        ONE_Q28      = 29'h1000_0000;
    localparam logic signed [32:0] ONE_Q30      = 33'sd1073741824;
    localparam logic [14:0]        THRESH_RESET = 15'd16;

    localparam logic signed [32:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
        33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
        33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
        33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
        33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
        33'sd1024,      33'sd512,       33'sd256,       33'sd128
    };

endpackage

`default_nettype wire

### design/qslerp_front.sv
`default_nettype none

module qslerp_front
    import qslerp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire req_t        req_data,
    input  wire logic [14:0] near_threshold,
    input  wire logic        full,
    output logic             push,
    output job_t             job
);

    logic                a_vld_reg;
    req_t                a_item_reg;
    logic signed [31:0]  a_prod_reg [4];
    logic                b_vld_reg;
    job_t                b_job_reg;

    logic                adv;
    req_t                item_next;
    logic signed [15:0]  qa [4];
    logic signed [15:0]  qb [4];
    logic signed [33:0]  dot;
    logic [33:0]         mag;
    logic [28:0]         c_next;
    logic [28:0]         gap;
    job_t                job_next;

    assign adv       = !(b_vld_reg && full);
    assign req_stall = !adv;
    assign push      = b_vld_reg && !full;
    assign job       = b_job_reg;

    assign qa[0] = req_data.first_x;
    assign qa[1] = req_data.first_y;
    assign qa[2] = req_data.first_z;
    assign qa[3] = req_data.first_w;
    assign qb[0] = req_data.second_x;
    assign qb[1] = req_data.second_y;
    assign qb[2] = req_data.second_z;
    assign qb[3] = req_data.second_w;

    always_comb
    begin
        item_next       = req_data;
        item_next.blend = (req_data.blend > ONE_Q14) ? ONE_Q14 : req_data.blend;
    end

    always_comb
    begin
        dot = 34'(a_prod_reg[0]) + 34'(a_prod_reg[1])
            + 34'(a_prod_reg[2]) + 34'(a_prod_reg[3]);
        mag = dot[33] ? 34'(-dot) : 34'(dot);
        c_next = (mag > {5'd0, ONE_Q28}) ? ONE_Q28 : mag[28:0];
        gap = ONE_Q28 - c_next;
        job_next.tag.item   = a_item_reg;
        job_next.tag.flip   = dot[33];
        job_next.tag.linear = gap < {near_threshold, 14'd0};
        job_next.mag        = c_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= req_valid;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= item_next;
            for (int i = 0; i < 4; i++)
            begin
                a_prod_reg[i] <= qa[i] * qb[i];
            end
            b_job_reg <= job_next;
        end
    end

endmodule

`default_nettype wire

### design/qslerp_fifo.sv
`default_nettype none

module qslerp_fifo
    import qslerp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_data,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_data,
    output logic      empty
);

    job_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### design/qslerp_back.sv
`default_nettype none

module qslerp_back
    import qslerp_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic empty,
    output logic      pop,
    input  wire job_t job,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp_data
);

    localparam int N = ANGLE_ITERATIONS;

    logic en;
    logic out_vld_reg;
    rsp_t out_data_reg;

    assign en        = !(out_vld_reg && rsp_stall);
    assign pop       = en && !empty;
    assign rsp_valid = out_vld_reg;
    assign rsp_data  = out_data_reg;

    // square of |dot|
    logic        s0_vld_reg;
    logic [56:0] s0_csq_reg;
    logic [28:0] s0_c_reg;
    tag_t        s0_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg <= !empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_csq_reg <= 57'(job.mag) * 57'(job.mag);
            s0_c_reg   <= job.mag;
            s0_tag_reg <= job.tag;
        end
    end

    // square root, one result bit per stage
    logic        sq_vld_reg [SQRT_STEPS];
    logic [56:0] sq_v_reg   [SQRT_STEPS];
    logic [57:0] sq_r_reg   [SQRT_STEPS];
    logic [28:0] sq_c_reg   [SQRT_STEPS];
    tag_t        sq_tag_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [57:0] BITK = 58'd1 << (56 - 2 * k);
        logic        vld_in;
        logic [56:0] v_in;
        logic [57:0] r_in;
        logic [28:0] c_in;
        tag_t        tag_in;
        logic [57:0] trial;
        logic        take;

        if (k == 0)
        begin : g_first
            assign vld_in = s0_vld_reg;
            assign v_in   = (57'd1 << 56) - s0_csq_reg;
            assign r_in   = '0;
            assign c_in   = s0_c_reg;
            assign tag_in = s0_tag_reg;
        end
        else
        begin : g_next
            assign vld_in = sq_vld_reg[k-1];
            assign v_in   = sq_v_reg[k-1];
            assign r_in   = sq_r_reg[k-1];
            assign c_in   = sq_c_reg[k-1];
            assign tag_in = sq_tag_reg[k-1];
        end

        assign trial = r_in + BITK;
        assign take  = {1'b0, v_in} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                sq_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_v_reg[k]   <= take ? (v_in - trial[56:0]) : v_in;
                sq_r_reg[k]   <= take ? ((r_in >> 1) + BITK) : (r_in >> 1);
                sq_c_reg[k]   <= c_in;
                sq_tag_reg[k] <= tag_in;
            end
        end
    end

    // angle of (c, s) by vectoring
    logic               an_vld_reg [N];
    logic signed [31:0] an_x_reg   [N];
    logic signed [31:0] an_y_reg   [N];
    logic signed [32:0] an_z_reg   [N];
    tag_t               an_tag_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_angle
        logic               vld_in;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [32:0] z_in;
        tag_t               tag_in;
        logic signed [31:0] dx;
        logic signed [31:0] dy;

        if (i == 0)
        begin : g_first
            assign vld_in = sq_vld_reg[SQRT_STEPS-1];
            assign x_in   = $signed({3'd0, sq_c_reg[SQRT_STEPS-1]});
            assign y_in   = $signed({3'd0, sq_r_reg[SQRT_STEPS-1][28:0]});
            assign z_in   = '0;
            assign tag_in = sq_tag_reg[SQRT_STEPS-1];
        end
        else
        begin : g_next
            assign vld_in = an_vld_reg[i-1];
            assign x_in   = an_x_reg[i-1];
            assign y_in   = an_y_reg[i-1];
            assign z_in   = an_z_reg[i-1];
            assign tag_in = an_tag_reg[i-1];
        end

        assign dx = y_in >>> i;
        assign dy = x_in >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                an_vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                an_vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_in > 0)
                begin
                    an_x_reg[i] <= x_in + dx;
                    an_y_reg[i] <= y_in - dy;
                    an_z_reg[i] <= z_in + ATAN_Q30[i];
                end
                else
                begin
                    an_x_reg[i] <= x_in - dx;
                    an_y_reg[i] <= y_in + dy;
                    an_z_reg[i] <= z_in - ATAN_Q30[i];
                end
                an_tag_reg[i] <= tag_in;
            end
        end
    end

    // scaled angles (1-t)*theta and t*theta
    logic               m_vld_reg;
    logic signed [32:0] m_theta_reg;
    logic signed [32:0] m_a1_reg;
    logic signed [32:0] m_a2_reg;
    tag_t               m_tag_reg;
    logic signed [32:0] theta;
    logic [14:0]        k1;
    logic signed [48:0] p1;
    logic signed [48:0] p2;

    assign theta = an_z_reg[N-1];
    assign k1    = ONE_Q14 - an_tag_reg[N-1].item.blend;
    assign p1    = $signed({1'b0, k1}) * theta;
    assign p2    = $signed({1'b0, an_tag_reg[N-1].item.blend}) * theta;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m_vld_reg <= an_vld_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_theta_reg <= theta;
            m_a1_reg    <= 33'(p1 >>> 14);
            m_a2_reg    <= 33'(p2 >>> 14);
            m_tag_reg   <= an_tag_reg[N-1];
        end
    end

    // three sine rotations side by side: sin(theta), sin(a1), sin(a2)
    logic               sn_vld_reg [N];
    tag_t               sn_tag_reg [N];
    logic signed [32:0] sn_x_reg   [3][N];
    logic signed [32:0] sn_y_reg   [3][N];
    logic signed [33:0] sn_z_reg   [3][N];

    for (genvar i = 0; i < N; i++)
    begin : g_sine_ctl
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sn_vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                sn_vld_reg[i] <= (i == 0) ? m_vld_reg : sn_vld_reg[(i == 0) ? 0 : i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sn_tag_reg[i] <= (i == 0) ? m_tag_reg : sn_tag_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        for (genvar i = 0; i < N; i++)
        begin : g_sine
            logic signed [32:0] x_in;
            logic signed [32:0] y_in;
            logic signed [33:0] z_in;
            logic signed [32:0] dx;
            logic signed [32:0] dy;

            if (i == 0)
            begin : g_first
                assign x_in = ONE_Q30;
                assign y_in = '0;
                if (l == 0)
                begin : g_theta
                    assign z_in = 34'(m_theta_reg);
                end
                else if (l == 1)
                begin : g_a1
                    assign z_in = 34'(m_a1_reg);
                end
                else
                begin : g_a2
                    assign z_in = 34'(m_a2_reg);
                end
            end
            else
            begin : g_next
                assign x_in = sn_x_reg[l][i-1];
                assign y_in = sn_y_reg[l][i-1];
                assign z_in = sn_z_reg[l][i-1];
            end

            assign dx = y_in >>> i;
            assign dy = x_in >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (z_in >= 0)
                    begin
                        sn_x_reg[l][i] <= x_in - dx;
                        sn_y_reg[l][i] <= y_in + dy;
                        sn_z_reg[l][i] <= z_in - 34'(ATAN_Q30[i]);
                    end
                    else
                    begin
                        sn_x_reg[l][i] <= x_in + dx;
                        sn_y_reg[l][i] <= y_in - dy;
                        sn_z_reg[l][i] <= z_in + 34'(ATAN_Q30[i]);
                    end
                end
            end
        end
    end

    // division setup
    logic               d0_vld_reg;
    tag_t               d0_tag_reg;
    logic               d0_use_reg;
    logic [30:0]        d0_d_reg;
    logic [46:0]        d0_r_reg    [2];
    logic [1:0]         d0_zero_reg;
    logic [1:0]         d0_ovf_reg;
    logic signed [32:0] st;
    logic signed [32:0] sw [2];
    logic [1:0]         zero_next;
    logic [1:0]         ovf_next;

    assign st    = sn_y_reg[0][N-1];
    assign sw[0] = sn_y_reg[1][N-1];
    assign sw[1] = sn_y_reg[2][N-1];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            zero_next[l] = (sw[l] <= 0);
            ovf_next[l]  = ({2'b0, sw[l][31:0]} >= {st[31:0], 2'b00});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            d0_vld_reg <= sn_vld_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_tag_reg  <= sn_tag_reg[N-1];
            d0_use_reg  <= (st > 0) && !sn_tag_reg[N-1].linear;
            d0_d_reg    <= st[30:0];
            d0_r_reg[0] <= {1'b0, sw[0][31:0], 14'd0};
            d0_r_reg[1] <= {1'b0, sw[1][31:0], 14'd0};
            d0_zero_reg <= zero_next;
            d0_ovf_reg  <= ovf_next;
        end
    end

    // restoring division, one quotient bit per stage, two lanes
    logic        dv_vld_reg  [DIV_STEPS];
    tag_t        dv_tag_reg  [DIV_STEPS];
    logic        dv_use_reg  [DIV_STEPS];
    logic [30:0] dv_d_reg    [DIV_STEPS];
    logic [1:0]  dv_zero_reg [DIV_STEPS];
    logic [1:0]  dv_ovf_reg  [DIV_STEPS];
    logic [46:0] dv_r_reg    [2][DIV_STEPS];
    logic [15:0] dv_q_reg    [2][DIV_STEPS];

    for (genvar m = 0; m < DIV_STEPS; m++)
    begin : g_div
        localparam int J = DIV_STEPS - 1 - m;
        logic        vld_in;
        tag_t        tag_in;
        logic        use_in;
        logic [30:0] d_in;
        logic [1:0]  zero_in;
        logic [1:0]  ovf_in;
        logic [46:0] r_in [2];
        logic [15:0] q_in [2];
        logic [46:0] dsh;

        if (m == 0)
        begin : g_first
            assign vld_in  = d0_vld_reg;
            assign tag_in  = d0_tag_reg;
            assign use_in  = d0_use_reg;
            assign d_in    = d0_d_reg;
            assign zero_in = d0_zero_reg;
            assign ovf_in  = d0_ovf_reg;
            assign r_in[0] = d0_r_reg[0];
            assign r_in[1] = d0_r_reg[1];
            assign q_in[0] = '0;
            assign q_in[1] = '0;
        end
        else
        begin : g_next
            assign vld_in  = dv_vld_reg[m-1];
            assign tag_in  = dv_tag_reg[m-1];
            assign use_in  = dv_use_reg[m-1];
            assign d_in    = dv_d_reg[m-1];
            assign zero_in = dv_zero_reg[m-1];
            assign ovf_in  = dv_ovf_reg[m-1];
            assign r_in[0] = dv_r_reg[0][m-1];
            assign r_in[1] = dv_r_reg[1][m-1];
            assign q_in[0] = dv_q_reg[0][m-1];
            assign q_in[1] = dv_q_reg[1][m-1];
        end

        assign dsh = {16'd0, d_in} << J;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[m] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld_reg[m] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_tag_reg[m]  <= tag_in;
                dv_use_reg[m]  <= use_in;
                dv_d_reg[m]    <= d_in;
                dv_zero_reg[m] <= zero_in;
                dv_ovf_reg[m]  <= ovf_in;
                for (int l = 0; l < 2; l++)
                begin
                    if (r_in[l] >= dsh)
                    begin
                        dv_r_reg[l][m] <= r_in[l] - dsh;
                        dv_q_reg[l][m] <= q_in[l] | (16'd1 << J);
                    end
                    else
                    begin
                        dv_r_reg[l][m] <= r_in[l];
                        dv_q_reg[l][m] <= q_in[l];
                    end
                end
            end
        end
    end

    // weight select and component products
    localparam int LD = DIV_STEPS - 1;

    logic [14:0]        wq [2];
    logic [14:0]        w1u;
    logic [14:0]        w2u;
    logic signed [15:0] w1;
    logic signed [15:0] w2;
    tag_t               ptag;
    logic signed [15:0] qa [4];
    logic signed [15:0] qb [4];

    logic               p_vld_reg;
    logic signed [31:0] p_a_reg [4];
    logic signed [31:0] p_b_reg [4];

    assign ptag = dv_tag_reg[LD];
    assign qa[0] = ptag.item.first_x;
    assign qa[1] = ptag.item.first_y;
    assign qa[2] = ptag.item.first_z;
    assign qa[3] = ptag.item.first_w;
    assign qb[0] = ptag.item.second_x;
    assign qb[1] = ptag.item.second_y;
    assign qb[2] = ptag.item.second_z;
    assign qb[3] = ptag.item.second_w;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (dv_zero_reg[LD][l])
            begin
                wq[l] = '0;
            end
            else if (dv_ovf_reg[LD][l] || (dv_q_reg[l][LD] > 16'(ONE_Q14)))
            begin
                wq[l] = ONE_Q14;
            end
            else
            begin
                wq[l] = dv_q_reg[l][LD][14:0];
            end
        end
        w1u = dv_use_reg[LD] ? wq[0] : (ONE_Q14 - ptag.item.blend);
        w2u = dv_use_reg[LD] ? wq[1] : ptag.item.blend;
        w1  = $signed({1'b0, w1u});
        w2  = ptag.flip ? -$signed({1'b0, w2u}) : $signed({1'b0, w2u});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg <= dv_vld_reg[LD];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                p_a_reg[i] <= qa[i] * w1;
                p_b_reg[i] <= qb[i] * w2;
            end
        end
    end

    // round, saturate, output beat
    logic signed [32:0] acc [4];
    logic signed [18:0] rnd [4];
    logic signed [15:0] res [4];
    rsp_t               out_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            acc[i] = 33'(p_a_reg[i]) + 33'(p_b_reg[i]) + 33'sd8192;
            rnd[i] = 19'(acc[i] >>> 14);
            if (rnd[i] > 19'sd32767)
            begin
                res[i] = 16'sh7FFF;
            end
            else if (rnd[i] < -19'sd32768)
            begin
                res[i] = 16'sh8000;
            end
            else
            begin
                res[i] = rnd[i][15:0];
            end
        end
        out_next.out_x = res[0];
        out_next.out_y = res[1];
        out_next.out_z = res[2];
        out_next.out_w = res[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

### design/quaternion_slerp_top.sv
`default_nettype none

// Quaternion slerp in Q2.14 fixed point.
// Request channel (req_valid, req_stall, req_data): one beat carries two
// quaternions and the blend factor t. Response channel (rsp_valid,
// rsp_stall, rsp_data): one beat carries the interpolated quaternion.
// cfg_we / cfg_wdata write near_threshold; write it only while idle.
// Throughput: one beat per cycle while req_stall is low. The pipeline is two
// front stages, a squaring stage, a 29-stage square root, two CORDIC chains
// of ANGLE_ITERATIONS stages with an angle-scaling stage between them, a
// division setup stage, a 16-stage divider, product and output registers.
// A four-entry queue sits between the dot-product front and the back
// pipeline. When rsp_stall is high with a beat pending, the back pipeline
// holds, the queue fills and then req_stall rises.
// Reset empties the queue and all stages and sets near_threshold to 16.
module quaternion_slerp_top
    import qslerp_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire req_t        req_data,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output rsp_t             rsp_data,
    input  wire logic        cfg_we,
    input  wire logic [14:0] cfg_wdata
);

    logic [14:0] thresh_reg;
    logic        push;
    logic        full;
    logic        pop;
    logic        empty;
    job_t        push_job;
    job_t        pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            thresh_reg <= cfg_wdata;
        end
    end

    qslerp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_data       (req_data),
        .near_threshold (thresh_reg),
        .full           (full),
        .push           (push),
        .job            (push_job)
    );

    qslerp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_job),
        .empty     (empty)
    );

    qslerp_back #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop       (pop),
        .job       (pop_job),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire

### verif/quaternion_slerp_checker.sv
module quaternion_slerp_checker
    import qslerp_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire logic        req_stall,
    input  wire req_t        req_data,
    input  wire logic        rsp_valid,
    input  wire logic        rsp_stall,
    input  wire rsp_t        rsp_data,
    input  wire logic        cfg_we,
    input  wire logic [14:0] cfg_wdata,
    output int               errors,
    output int               pending
);

    localparam longint Q14 = 16384;
    localparam longint Q28 = 64'sd1 << 28;
    localparam longint Q30 = 64'sd1 << 30;

    longint threshold;
    rsp_t   slerp_q[$];

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > v) b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic int steps();
        return ANGLE_ITERATIONS > ATAN_ENTRIES ? ATAN_ENTRIES :
               (ANGLE_ITERATIONS < 0 ? 0 : ANGLE_ITERATIONS);
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < steps(); i++)
        begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
            end
        end
        return z;
    endfunction

    function automatic longint rotate_sine(longint z);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = Q30;
        y = 0;
        for (int i = 0; i < steps(); i++)
        begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
            end
        end
        return y;
    endfunction

    function automatic longint weight(longint num, longint den);
        longint w;
        w = (num * Q14) / den;
        if (w < 0) w = 0;
        if (w > Q14) w = Q14;
        return w;
    endfunction

    function automatic rsp_t slerp(req_t r);
        longint a[4];
        longint b[4];
        longint t;
        longint dot;
        longint c;
        longint w1;
        longint w2;
        longint s;
        longint th;
        longint st;
        longint v;
        logic   neg;
        rsp_t   o;
        a = '{longint'(r.first_x), longint'(r.first_y),
              longint'(r.first_z), longint'(r.first_w)};
        b = '{longint'(r.second_x), longint'(r.second_y),
              longint'(r.second_z), longint'(r.second_w)};
        t = longint'(r.blend);
        if (t > Q14) t = Q14;
        dot = a[0] * b[0] + a[1] * b[1] + a[2] * b[2] + a[3] * b[3];
        neg = dot < 0;
        c = neg ? -dot : dot;
        if (c > Q28) c = Q28;
        w1 = Q14 - t;
        w2 = t;
        if (Q28 - c >= (threshold << 14))
        begin
            s = root_floor((64'sd1 << 56) - c * c);
            th = vector_angle(c, s);
            st = rotate_sine(th);
            if (st > 0)
            begin
                w1 = weight(rotate_sine(fshift((Q14 - t) * th, 14)), st);
                w2 = weight(rotate_sine(fshift(t * th, 14)), st);
            end
        end
        if (neg) w2 = -w2;
        for (int i = 0; i < 4; i++)
        begin
            v = fshift(a[i] * w1 + b[i] * w2 + 8192, 14);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            case (i)
                0: o.out_x = v[15:0];
                1: o.out_y = v[15:0];
                2: o.out_z = v[15:0];
                default: o.out_w = v[15:0];
            endcase
        end
        return o;
    endfunction

    assign pending = slerp_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold = longint'(THRESH_RESET);
            errors = 0;
            slerp_q.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (slerp_q.size() == 0)
                begin
                    $display("%0t: unexpected beat %h", $time, rsp_data);
                    errors++;
                end
                else if (slerp_q[0] !== rsp_data)
                begin
                    $display("%0t: expected %h actual %h", $time, slerp_q[0], rsp_data);
                    errors++;
                    void'(slerp_q.pop_front());
                end
                else
                    void'(slerp_q.pop_front());
            end
            if (req_valid && !req_stall)
                slerp_q.push_back(slerp(req_data));
            if (cfg_we)
                threshold = longint'(cfg_wdata);
        end
    end

endmodule

### verif/quaternion_slerp_top_test.sv
module quaternion_slerp_top_test;
    import qslerp_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        req_valid = 0;
    logic        req_stall;
    req_t        req_data = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1;
    rsp_t        rsp_data;
    logic        cfg_we = 0;
    logic [14:0] cfg_wdata = '0;
    int          errors;
    int          pending;
    int          hold_off = 0;
    int          rsp_wait = 0;

    always #4 clk = ~clk;

    quaternion_slerp_top dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    quaternion_slerp_checker chk (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    function automatic logic [15:0] unit_part();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 32768)) - 16384);
            2: return 16'($signed($urandom_range(0, 16384)) - 8192);
            default: return 16'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    function automatic logic [14:0] pick_blend();
        case ($urandom_range(0, 5))
            0: return 15'($urandom);
            1: return 15'd0;
            2: return ONE_Q14;
            default: return 15'($urandom_range(0, 16384));
        endcase
    endfunction

    function automatic req_t random_beat();
        req_t r;
        logic [15:0] d;
        r.first_x = unit_part();
        r.first_y = unit_part();
        r.first_z = unit_part();
        r.first_w = unit_part();
        case ($urandom_range(0, 4))
            0:
            begin
                r.second_x = r.first_x; r.second_y = r.first_y;
                r.second_z = r.first_z; r.second_w = r.first_w;
            end
            1:
            begin
                r.second_x = -r.first_x; r.second_y = -r.first_y;
                r.second_z = -r.first_z; r.second_w = -r.first_w;
            end
            2:
            begin
                d = 16'($signed($urandom_range(0, 200)) - 100);
                r.second_x = r.first_x + d; r.second_y = r.first_y;
                r.second_z = r.first_z - d; r.second_w = r.first_w;
            end
            default:
            begin
                r.second_x = unit_part(); r.second_y = unit_part();
                r.second_z = unit_part(); r.second_w = unit_part();
            end
        endcase
        r.blend = pick_blend();
        return r;
    endfunction

    task automatic send(req_t r);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            req_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1;
        req_data <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic quiesce();
        int guard;
        guard = 0;
        req_valid <= 0;
        while (pending != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (100) @(negedge clk);
    endtask

    task automatic set_threshold(logic [14:0] v);
        @(negedge clk);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic directed();
        req_t r;
        logic [15:0] e [4];
        e = '{16'h8000, 16'h7fff, 16'h4000, 16'h0000};
        for (int i = 0; i < 4; i++)
        begin
            r = '{e[i], e[(i+1)%4], e[(i+2)%4], e[(i+3)%4],
                  e[(i+2)%4], e[(i+3)%4], e[i], e[(i+1)%4], 15'h7fff};
            send(r);
            r.blend = 15'd0;
            send(r);
        end
        send('{16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 15'd8192});
        send('{16'h4000, 16'h0, 16'h0, 16'h0, 16'hc000, 16'h0, 16'h0, 16'h0, 15'd4096});
        send('{16'h4000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 15'd8192});
        send('{16'h4000, 16'h0, 16'h0, 16'h0, 16'h2d41, 16'h2d41, 16'h0, 16'h0, ONE_Q14});
        send('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
               16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 15'd100});
        send('{16'h4000, 16'h0, 16'h0, 16'h0, 16'h3fff, 16'h0100, 16'h0, 16'h0, 15'd12000});
        send('{16'h4000, 16'h0, 16'h0, 16'h0, 16'h3fff, 16'h0100, 16'h0, 16'h0, 15'd16385});
        send('{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 15'd5000});
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1;
            rsp_wait <= 0;
        end
        else if (hold_off > 0)
        begin
            rsp_stall <= 1;
            hold_off <= hold_off - 1;
        end
        else if (rsp_wait > 0)
        begin
            rsp_stall <= 1;
            rsp_wait <= rsp_wait - 1;
        end
        else
        begin
            rsp_stall <= 0;
            if (rsp_valid)
                rsp_wait <= ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 18));
        end
    end

    initial
    begin
        logic [14:0] levels [5];
        levels = '{15'd16, 15'd0, 15'd16384, 15'd300, 15'h7fff};
        repeat (10) @(negedge clk);
        rst_n <= 1;
        directed();
        for (int p = 0; p < 5; p++)
        begin
            quiesce();
            set_threshold(levels[p]);
            if (p == 1)
                hold_off <= 400;
            for (int i = 0; i < 340; i++)
                send(random_beat());
        end
        quiesce();
        if (errors == 0 && pending == 0)
            $display("quaternion_slerp_top_test OK");
        else
            $display("quaternion_slerp_top_test NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("quaternion_slerp_top_test NOT OK");
        $finish;
    end

endmodule

### quaternion_slerp_top.f
design/qslerp_pkg.sv
design/qslerp_front.sv
design/qslerp_fifo.sv
design/qslerp_back.sv
design/quaternion_slerp_top.sv
verif/quaternion_slerp_checker.sv
verif/quaternion_slerp_top_test.sv
